@@ design/arp_pkg.sv @@
// Package for the ARP resolver: widths, codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none
package arp_pkg;
  localparam int CacheEntries = 16;
  localparam int QueueDepth   = 16;
  localparam int CIdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int QIdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW = $clog2(QueueDepth + 1);
  localparam int CCntW = $clog2(CacheEntries + 1);

  localparam logic [15:0] HoldoffReset  = 16'(5 * 1000);
  localparam logic [19:0] LifetimeReset = 20'(30 * 1000);
  localparam logic [47:0] BroadcastMac  = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] Max48         = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] OpSend = 2'd0;
  localparam logic [1:0] OpRecv = 2'd1;
  localparam logic [1:0] OpTick = 2'd2;

  localparam logic [2:0] KindIpv4    = 3'd0;
  localparam logic [2:0] KindArpReq  = 3'd1;
  localparam logic [2:0] KindArpRep  = 3'd2;
  localparam logic [2:0] KindDeliver = 3'd3;
  localparam logic [2:0] KindDrop    = 3'd4;

  localparam logic [1:0] RegLocalMac = 2'd0;
  localparam logic [1:0] RegLocalIp  = 2'd1;
  localparam logic [1:0] RegHoldoff  = 2'd2;
  localparam logic [1:0] RegLifetime = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_SEND_SCAN, ST_SEND_DONE, ST_LEARN_SCAN, ST_LEARN_WR,
    ST_REPLY, ST_FLUSH_ITEM, ST_FLUSH_SCAN, ST_FLUSH_STEP, ST_TICK_SCAN, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] dst_mac;
    logic [15:0] out_tag;
    logic [31:0] tip;
    logic [47:0] tmac;
  } result_t;

  typedef enum logic [3:0] {
    EV_NONE, EV_IPV4_HIT, EV_DROP, EV_REQ, EV_DELIVER, EV_REPLY, EV_FLUSH_OUT
  } event_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // capture the input item
    logic    clr_scan;    // restart the cache scan counter
    logic    step_cache;  // examine one cache entry
    logic    step_queue;  // examine one queue entry (send: recent check)
    logic    send_commit; // append to queue or not
    logic    learn_write;
    logic    tick_now;    // advance the clock
    logic    tick_step;   // expire one cache entry
    logic    flush_start;
    logic    flush_keep;  // copy current queue entry down
    logic    flush_adv;   // advance to next queue entry
    logic    flush_end;
    logic    lookup_q;    // scan cache for current queue IP
    logic    pop_stage;   // move the staged result to the output register
    event_t  ev;          // result to build (reply and flush results go to the stage)
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       for_us;
    logic       ok;
    logic       is_ipv4;
    logic       want_reply;
    logic       scan_done;   // cache scan finished
    logic       qscan_done;  // queue scan finished
    logic       hit;
    logic       recent;
    logic       q_full;
    logic       fl_done;     // flush read pointer past the last queue entry
    logic       fl_valid;    // entry under the read pointer
  } stat_t;
endpackage
`default_nettype wire

@@ design/arp_ctrl.sv @@
// Controller state machine for the ARP resolver.
// Depends on arp_pkg; drives arp_dp through cmd_t and reads stat_t.
`default_nettype none
module arp_ctrl
  import arp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_fire,
  input  wire logic  out_free,   // output register empty or being taken
  input  wire stat_t st,
  output logic       busy,
  output cmd_t       cmd,
  output logic       emit,
  output logic       emit_last
);
  state_t state, state_next, ret, ret_next;
  logic   pend_req, pend_req_next;
  logic   staged, staged_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret <= ST_IDLE;
      pend_req <= 1'b0;
      staged <= 1'b0;
    end else begin
      state <= state_next;
      ret <= ret_next;
      pend_req <= pend_req_next;
      staged <= staged_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    ret_next = ret;
    pend_req_next = pend_req;
    staged_next = staged;
    cmd = '0;
    cmd.ev = EV_NONE;
    emit = 1'b0;
    emit_last = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.clr_scan = 1'b1;
        priority if (st.op == OpSend) state_next = ST_SEND_SCAN;
        else if (st.op == OpTick) begin
          cmd.tick_now = 1'b1;
          state_next = ST_TICK_SCAN;
        end else if (st.op == OpRecv && st.for_us && st.ok) begin
          if (st.is_ipv4) begin
            if (out_free) begin
              cmd.ev = EV_DELIVER; emit = 1'b1; emit_last = 1'b1;
              state_next = ST_IDLE;
            end else begin
              cmd.clr_scan = 1'b0;
            end
          end else state_next = ST_LEARN_SCAN;
        end else state_next = ST_IDLE;
      end
      ST_SEND_SCAN: begin
        cmd.step_cache = 1'b1;
        cmd.step_queue = 1'b1;
        if (st.scan_done && st.qscan_done) state_next = ST_SEND_DONE;
      end
      ST_SEND_DONE: begin
        if (out_free) begin
          if (st.hit) begin
            cmd.ev = EV_IPV4_HIT; emit = 1'b1; emit_last = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.send_commit = 1'b1;
            if (st.q_full) begin
              cmd.ev = EV_DROP; emit = 1'b1; emit_last = st.recent;
              if (st.recent) state_next = ST_IDLE;
              else begin
                pend_req_next = 1'b1;
                state_next = ST_EMIT;
              end
            end else if (!st.recent) begin
              cmd.ev = EV_REQ; emit = 1'b1; emit_last = 1'b1;
              state_next = ST_IDLE;
            end else state_next = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.ev = EV_REQ; emit = 1'b1; emit_last = 1'b1;
          pend_req_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      ST_LEARN_SCAN: begin
        cmd.step_cache = 1'b1;
        if (st.scan_done) state_next = ST_LEARN_WR;
      end
      ST_LEARN_WR: begin
        cmd.learn_write = 1'b1;
        cmd.flush_start = 1'b1;
        state_next = st.want_reply ? ST_REPLY : ST_FLUSH_ITEM;
      end
      ST_REPLY: begin
        // stage the reply until it is known whether a flush result follows
        cmd.ev = EV_REPLY;
        staged_next = 1'b1;
        state_next = ST_FLUSH_ITEM;
      end
      ST_FLUSH_ITEM: begin
        cmd.clr_scan = 1'b1;
        if (st.fl_done || !st.fl_valid) begin
          if (!staged) begin
            cmd.flush_end = 1'b1;
            state_next = ST_IDLE;
          end else if (out_free) begin
            // the staged result is the final one of this item
            cmd.flush_end = 1'b1;
            cmd.pop_stage = 1'b1;
            emit = 1'b1; emit_last = 1'b1;
            staged_next = 1'b0;
            state_next = ST_IDLE;
          end
        end else state_next = ST_FLUSH_SCAN;
      end
      ST_FLUSH_SCAN: begin
        cmd.lookup_q = 1'b1;
        if (st.scan_done) state_next = ST_FLUSH_STEP;
      end
      ST_FLUSH_STEP: begin
        if (st.hit) begin
          if (!staged || out_free) begin
            // release the older staged result and stage this one
            cmd.ev = EV_FLUSH_OUT;
            cmd.pop_stage = staged;
            emit = staged;
            cmd.flush_adv = 1'b1;
            staged_next = 1'b1;
            state_next = ST_FLUSH_ITEM;
          end
        end else begin
          cmd.flush_keep = 1'b1;
          cmd.flush_adv = 1'b1;
          state_next = ST_FLUSH_ITEM;
        end
      end
      ST_TICK_SCAN: begin
        cmd.tick_step = 1'b1;
        if (st.scan_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  property p_load_idle;
    @(posedge clk) disable iff (rst) cmd.load |-> state == ST_IDLE;
  endproperty
  a_load_idle: assert property (p_load_idle) else $error("load outside idle");
  a_emit_free: assert property (@(posedge clk) disable iff (rst) emit |-> out_free)
    else $error("result emitted into full output register");
  a_pend: assert property (@(posedge clk) disable iff (rst)
    pend_req |-> state == ST_EMIT) else $error("pending request outside emit");
  a_staged_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !staged) else $error("staged result left behind");
endmodule
`default_nettype wire

@@ design/arp_dp.sv @@
// Datapath of the ARP resolver: registers, cache and queue tables, clock,
// scan counters and the result register. Depends on arp_pkg; driven by arp_ctrl.
`default_nettype none
module arp_dp
  import arp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cmd_t         cmd,
  output stat_t             st,
  input  wire logic         cfg_fire,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [47:0]  cfg_data,
  input  wire logic [1:0]   i_op,
  input  wire logic [31:0]  i_nh_ip,
  input  wire logic [15:0]  i_tag,
  input  wire logic [47:0]  i_dst_mac,
  input  wire logic         i_is_ipv4,
  input  wire logic         i_ok,
  input  wire logic         i_is_reply,
  input  wire logic [31:0]  i_sip,
  input  wire logic [47:0]  i_smac,
  input  wire logic [31:0]  i_tip,
  input  wire logic [15:0]  i_elapsed,
  output result_t           res
);
  logic [47:0] local_mac;
  logic [31:0] local_ip;
  logic [15:0] holdoff;
  logic [19:0] lifetime;
  logic [47:0] now_ms;

  logic [1:0]  op;
  logic [31:0] nh_ip, sip, tip;
  logic [15:0] tag, elapsed;
  logic [47:0] dmac, smac;
  logic        is_ipv4, ok, is_reply;

  logic [CacheEntries-1:0] c_valid;
  logic [31:0] c_ip  [CacheEntries];
  logic [47:0] c_mac [CacheEntries];
  logic [47:0] c_exp [CacheEntries];
  logic [QueueDepth-1:0] q_valid;
  logic [31:0] q_ip  [QueueDepth];
  logic [15:0] q_tag [QueueDepth];
  logic [47:0] q_dl  [QueueDepth];

  logic [CCntW-1:0] cptr;
  logic [QCntW-1:0] qptr, rd, wr, qcount;
  logic             hit, recent, have_free, have_min;
  logic [CIdxW-1:0] hit_idx, free_idx, min_idx;
  logic [47:0]      min_exp, hit_mac;
  result_t          stage;

  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? Max48 : s[47:0];
  endfunction

  wire [CIdxW-1:0] ci = cptr[CIdxW-1:0];
  wire [QIdxW-1:0] qi = qptr[QIdxW-1:0];
  wire [QIdxW-1:0] ri = rd[QIdxW-1:0];
  wire [QIdxW-1:0] wi = wr[QIdxW-1:0];
  wire [31:0] look_ip = cmd.lookup_q ? q_ip[ri] : ((op == OpSend) ? nh_ip : sip);
  wire [47:0] new_exp = sat_add(now_ms, {28'd0, lifetime});

  always_ff @(posedge clk) begin
    if (rst) begin
      local_mac <= '0;
      local_ip <= '0;
      holdoff <= HoldoffReset;
      lifetime <= LifetimeReset;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        RegLocalMac: local_mac <= cfg_data;
        RegLocalIp:  local_ip <= cfg_data[31:0];
        RegHoldoff:  holdoff <= cfg_data[15:0];
        RegLifetime: lifetime <= cfg_data[19:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= i_op; nh_ip <= i_nh_ip; tag <= i_tag; dmac <= i_dst_mac;
      is_ipv4 <= i_is_ipv4; ok <= i_ok; is_reply <= i_is_reply;
      sip <= i_sip; smac <= i_smac; tip <= i_tip; elapsed <= i_elapsed;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      cptr <= '0; qptr <= '0; hit <= 1'b0; recent <= 1'b0;
      have_free <= 1'b0; have_min <= 1'b0;
    end else if (cmd.clr_scan) begin
      cptr <= '0; qptr <= '0; hit <= 1'b0; recent <= 1'b0;
      have_free <= 1'b0; have_min <= 1'b0;
    end else begin
      if ((cmd.step_cache || cmd.lookup_q || cmd.tick_step) &&
          cptr != CCntW'(CacheEntries)) begin
        cptr <= cptr + CCntW'(1);
        if (!cmd.tick_step) begin
          if (c_valid[ci] && c_ip[ci] == look_ip && !hit) begin
            hit <= 1'b1; hit_idx <= ci; hit_mac <= c_mac[ci];
          end
          if (!c_valid[ci] && !have_free) begin
            have_free <= 1'b1; free_idx <= ci;
          end
          if (c_valid[ci] && (!have_min || c_exp[ci] < min_exp)) begin
            have_min <= 1'b1; min_idx <= ci; min_exp <= c_exp[ci];
          end
        end
      end
      if (cmd.step_queue && qptr != QCntW'(QueueDepth)) begin
        qptr <= qptr + QCntW'(1);
        if (q_valid[qi] && q_ip[qi] == nh_ip && q_dl[qi] > now_ms) recent <= 1'b1;
      end
      if (cmd.flush_adv) hit <= 1'b0;
    end
  end

  always_comb begin
    qcount = '0;
    for (int k = 0; k < QueueDepth; k++) qcount = qcount + QCntW'(q_valid[k]);
  end

  // cache
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= '0;
    end else begin
      if (cmd.tick_step && cptr != CCntW'(CacheEntries) &&
          c_valid[ci] && c_exp[ci] < now_ms)
        c_valid[ci] <= 1'b0;
      if (cmd.learn_write) begin
        c_valid[hit ? hit_idx : (have_free ? free_idx : min_idx)] <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.learn_write) begin
      c_ip [hit ? hit_idx : (have_free ? free_idx : min_idx)] <= sip;
      c_mac[hit ? hit_idx : (have_free ? free_idx : min_idx)] <= smac;
      c_exp[hit ? hit_idx : (have_free ? free_idx : min_idx)] <= new_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) now_ms <= '0;
    else if (cmd.tick_now) now_ms <= sat_add(now_ms, {32'd0, elapsed});
  end

  // queue: append on send, compact on flush
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= '0; rd <= '0; wr <= '0;
    end else begin
      if (cmd.send_commit && qcount != QCntW'(QueueDepth))
        q_valid[qcount[QIdxW-1:0]] <= 1'b1;
      if (cmd.flush_start) begin
        rd <= '0; wr <= '0;
      end
      if (cmd.flush_adv) rd <= rd + QCntW'(1);
      if (cmd.flush_keep) wr <= wr + QCntW'(1);
      if (cmd.flush_end) begin
        for (int k = 0; k < QueueDepth; k++) q_valid[k] <= (QCntW'(k) < wr);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.send_commit && qcount != QCntW'(QueueDepth)) begin
      q_ip [qcount[QIdxW-1:0]] <= nh_ip;
      q_tag[qcount[QIdxW-1:0]] <= tag;
      q_dl [qcount[QIdxW-1:0]] <= recent ? now_ms : sat_add(now_ms, {32'd0, holdoff});
    end
    if (cmd.flush_keep) begin
      q_ip[wi] <= q_ip[ri]; q_tag[wi] <= q_tag[ri]; q_dl[wi] <= q_dl[ri];
    end
  end

  // stage: holds a reply or flush result until the next one is known
  always_ff @(posedge clk) begin
    unique case (cmd.ev)
      EV_REPLY:     stage <= '{KindArpRep, smac, 16'd0, sip, smac};
      EV_FLUSH_OUT: stage <= '{KindIpv4, hit_mac, q_tag[ri], 32'd0, 48'd0};
      default:      stage <= stage;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.pop_stage) begin
      res <= stage;
    end else begin
      unique case (cmd.ev)
        EV_IPV4_HIT:  res <= '{KindIpv4, hit_mac, tag, 32'd0, 48'd0};
        EV_DROP:      res <= '{KindDrop, 48'd0, tag, 32'd0, 48'd0};
        EV_REQ:       res <= '{KindArpReq, BroadcastMac, 16'd0, nh_ip, 48'd0};
        EV_DELIVER:   res <= '{KindDeliver, 48'd0, tag, 32'd0, 48'd0};
        default:      res <= res;
      endcase
    end
  end

  always_comb begin
    st.op = op;
    st.for_us = (dmac == local_mac) || (dmac == BroadcastMac);
    st.ok = ok;
    st.is_ipv4 = is_ipv4;
    st.want_reply = !is_reply && (tip == local_ip);
    st.scan_done = (cptr == CCntW'(CacheEntries));
    st.qscan_done = (qptr == QCntW'(QueueDepth));
    st.hit = hit;
    st.recent = recent;
    st.q_full = (qcount == QCntW'(QueueDepth));
    st.fl_done = (rd == QCntW'(QueueDepth));
    st.fl_valid = q_valid[ri];
  end

  a_wr_rd: assert property (@(posedge clk) disable iff (rst) wr <= rd)
    else $error("compaction write pointer passed read pointer");
  a_learn: assert property (@(posedge clk) disable iff (rst)
    cmd.learn_write |=> c_valid != '0) else $error("learn left cache empty");
  a_tick: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_now |=> now_ms >= $past(now_ms)) else $error("clock went backwards");
endmodule
`default_nettype wire

@@ design/arp_resolver_with_pending_queue.sv @@
// ARP resolver with pending queue: top level joining controller and datapath.
// Depends on arp_pkg, arp_ctrl and arp_dp.
//
// Usage: items enter on s_axis (send, received frame or tick, selected by
// s_axis_tuser). Results leave on m_axis, one per transfer, with m_axis_tlast on
// the final result of an item. Registers are written on the cfg channel
// (index 0 local MAC, 1 local IP, 2 request holdoff, 3 entry lifetime); the user
// must write them only while idle, which the block itself does not enforce.
// One item is worked at a time; s_axis_tready is high only when the controller
// is idle and stays low after an accept until the item is finished. A tick is
// dispatched, then an expiry scan visits every cache entry. A send scans cache
// and queue together, one entry each per cycle; a full queue gives a drop, which
// may be followed by a request. A received IPv4 frame is delivered at dispatch
// once the output is free. A received ARP frame is learned after a full cache
// scan, then gets a reply if one is wanted, a full cache lookup per queued
// datagram and a final step. A reply or released datagram is staged until the
// next result or the end of the item is known. The output register holds one
// result; when the receiver stalls the controller waits before emitting the next
// one. Reset clears cache and queue valid bits and the clock at once; no clearing pass.
`default_nettype none
module arp_resolver_with_pending_queue
  import arp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // tdata: hop_ip[31:0], datagram_tag[47:32], frame_dst_mac[95:48],
  // frame_is_ipv4[96], payload_ok[97], arp_is_reply[98], arp_sender_ip[130:99],
  // arp_sender_mac[178:131], arp_target_ip_in[210:179], elapsed_ms[226:211]
  input  wire logic [231:0]  s_axis_tdata,
  // tuser: operation[1:0]
  input  wire logic [1:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // tdata: dst_mac[47:0], out_tag[63:48], arp_target_ip_out[95:64],
  // arp_target_mac_out[143:96]
  output logic [143:0]       m_axis_tdata,
  // tuser: kind[2:0]
  output logic [2:0]         m_axis_tuser,
  output logic               m_axis_tlast,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [47:0]   cfg_data
);
  cmd_t    cmd;
  stat_t   st;
  result_t res;
  logic    busy, emit, emit_last, out_free, in_fire;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      m_axis_tlast <= 1'b0;
    end else begin
      if (emit) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tlast <= emit_last;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  arp_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_free, .st, .busy, .cmd, .emit, .emit_last
  );

  arp_dp u_dp (
    .clk, .rst, .cmd, .st,
    .cfg_fire(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .i_op(s_axis_tuser), .i_nh_ip(s_axis_tdata[31:0]), .i_tag(s_axis_tdata[47:32]),
    .i_dst_mac(s_axis_tdata[95:48]), .i_is_ipv4(s_axis_tdata[96]),
    .i_ok(s_axis_tdata[97]), .i_is_reply(s_axis_tdata[98]),
    .i_sip(s_axis_tdata[130:99]), .i_smac(s_axis_tdata[178:131]),
    .i_tip(s_axis_tdata[210:179]), .i_elapsed(s_axis_tdata[226:211]),
    .res
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {res.tmac, res.tip, res.out_tag, res.dst_mac};
endmodule
`default_nettype wire

@@ tb/tb_arp_resolver_with_pending_queue.sv @@
// Testbench for the ARP resolver: directed and random items with a cycle-free
// behavioural predictor of cache, pending queue and clock. Depends on arp_pkg and arp_resolver_with_pending_queue.
`default_nettype none
module tb_arp_resolver_with_pending_queue;
  import arp_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int DrainCycles = 400;
  localparam int StallLimit  = 20000;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] hop_ip;
    logic [15:0] tag;
    logic [47:0] dst;
    bit          v4, ok, rep;
    logic [31:0] sip;
    logic [47:0] smac;
    logic [31:0] tip;
    logic [15:0] elapsed;
  } net_item_t;

  typedef struct {
    logic [2:0]  kind;
    logic [47:0] dst_mac;
    logic [15:0] tag;
    logic [31:0] tip;
    logic [47:0] tmac;
    bit          last;
  } frame_out_t;

  typedef struct {
    logic [31:0] ip;
    logic [15:0] tag;
    logic [47:0] deadline;
  } pending_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [231:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [143:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  arp_resolver_with_pending_queue u_dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial forever #5 clk = ~clk;

  // predictor state
  logic [47:0] my_mac, now_ms;
  logic [31:0] my_ip;
  logic [15:0] holdoff;
  logic [19:0] lifetime;
  bit          arp_valid[CacheEntries];
  logic [31:0] arp_ip[CacheEntries];
  logic [47:0] arp_mac[CacheEntries];
  logic [47:0] arp_expiry[CacheEntries];
  pending_t    pending[$];
  frame_out_t  expected_frames[$];
  frame_out_t  step_frames[$];

  int  errors = 0;
  bit  calm = 0;
  int  quiet_cycles = 0;
  logic [31:0] ip_pool[24];

  function automatic logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? Max48 : s[47:0];
  endfunction

  function automatic void push_frame(logic [2:0] k, logic [47:0] d, logic [15:0] t,
                                     logic [31:0] ip, logic [47:0] m);
    frame_out_t f;
    f = '{k, d, t, ip, m, 0};
    step_frames.insert(step_frames.size(), f);
  endfunction

  function automatic int cache_lookup(logic [31:0] ip);
    for (int i = 0; i < CacheEntries; i++)
      if (arp_valid[i] && arp_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic void learn_mapping(logic [31:0] ip, logic [47:0] mac);
    int slot;
    slot = cache_lookup(ip);
    if (slot < 0)
      for (int i = 0; i < CacheEntries && slot < 0; i++)
        if (!arp_valid[i]) slot = i;
    if (slot < 0) begin
      slot = 0;
      for (int i = 1; i < CacheEntries; i++)
        if (arp_expiry[i] < arp_expiry[slot]) slot = i;
    end
    arp_valid[slot] = 1;
    arp_ip[slot] = ip;
    arp_mac[slot] = mac;
    arp_expiry[slot] = sat_add(now_ms, 48'(lifetime));
  endfunction

  // work out the frames one accepted item causes and queue them
  function automatic void predict_frames(net_item_t it);
    int hit;
    bit recent;
    pending_t kept[$];
    pending_t entry;
    step_frames.delete();
    case (it.op)
      OpSend: begin
        hit = cache_lookup(it.hop_ip);
        if (hit >= 0) begin
          push_frame(KindIpv4, arp_mac[hit], it.tag, '0, '0);
        end else begin
          recent = 0;
          foreach (pending[i])
            if (pending[i].ip == it.hop_ip && pending[i].deadline > now_ms) recent = 1;
          if (pending.size() < QueueDepth) begin
            entry = '{it.hop_ip, it.tag,
                      recent ? now_ms : sat_add(now_ms, 48'(holdoff))};
            pending.insert(pending.size(), entry);
          end else
            push_frame(KindDrop, '0, it.tag, '0, '0);
          if (!recent) push_frame(KindArpReq, BroadcastMac, '0, it.hop_ip, '0);
        end
      end
      OpRecv: begin
        if ((it.dst == my_mac || it.dst == BroadcastMac) && it.ok) begin
          if (it.v4) begin
            push_frame(KindDeliver, '0, it.tag, '0, '0);
          end else begin
            learn_mapping(it.sip, it.smac);
            if (!it.rep && it.tip == my_ip)
              push_frame(KindArpRep, it.smac, '0, it.sip, it.smac);
            foreach (pending[i]) begin
              hit = cache_lookup(pending[i].ip);
              if (hit >= 0) push_frame(KindIpv4, arp_mac[hit], pending[i].tag, '0, '0);
              else kept.insert(kept.size(), pending[i]);
            end
            pending = kept;
          end
        end
      end
      OpTick: begin
        now_ms = sat_add(now_ms, 48'(it.elapsed));
        for (int i = 0; i < CacheEntries; i++)
          if (arp_valid[i] && arp_expiry[i] < now_ms) arp_valid[i] = 0;
      end
      default: ;
    endcase
    if (step_frames.size() > 0) step_frames[$].last = 1;
    foreach (step_frames[i]) expected_frames.insert(expected_frames.size(), step_frames[i]);
  endfunction

  task automatic report(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // check each result item against the oldest expectation
  always @(negedge clk) begin
    frame_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        report($sformatf("unexpected frame kind %0d", m_axis_tuser));
      end else begin
        want = expected_frames.pop_front();
        if (m_axis_tuser !== want.kind)
          report($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
        if (m_axis_tdata[47:0] !== want.dst_mac)
          report($sformatf("dst_mac %h, want %h", m_axis_tdata[47:0], want.dst_mac));
        if (m_axis_tdata[63:48] !== want.tag)
          report($sformatf("tag %h, want %h", m_axis_tdata[63:48], want.tag));
        if (m_axis_tdata[95:64] !== want.tip)
          report($sformatf("target ip %h, want %h", m_axis_tdata[95:64], want.tip));
        if (m_axis_tdata[143:96] !== want.tmac)
          report($sformatf("target mac %h, want %h", m_axis_tdata[143:96], want.tmac));
        if (m_axis_tlast !== want.last)
          report($sformatf("last %0b, want %0b", m_axis_tlast, want.last));
      end
    end
  end

  always @(posedge clk)
    m_axis_tready <= calm || ($urandom_range(99) >= 8);

  always @(negedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles > StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  function automatic net_item_t noise_item();
    net_item_t it;
    it = '{2'($urandom), $urandom, 16'($urandom), rand48(), 1'($urandom), 1'($urandom),
           1'($urandom), $urandom, rand48(), $urandom, 16'($urandom)};
    return it;
  endfunction

  function automatic net_item_t send_item_of(logic [31:0] ip, logic [15:0] tag);
    net_item_t it;
    it = noise_item();
    it.op = OpSend; it.hop_ip = ip; it.tag = tag;
    return it;
  endfunction

  function automatic net_item_t arp_item_of(logic [47:0] dst, bit rep, logic [31:0] sip,
                                            logic [47:0] smac, logic [31:0] tip, bit ok);
    net_item_t it;
    it = noise_item();
    it.op = OpRecv; it.dst = dst; it.v4 = 0; it.ok = ok; it.rep = rep;
    it.sip = sip; it.smac = smac; it.tip = tip;
    return it;
  endfunction

  function automatic net_item_t ipv4_item_of(logic [47:0] dst, logic [15:0] tag, bit ok);
    net_item_t it;
    it = noise_item();
    it.op = OpRecv; it.dst = dst; it.v4 = 1; it.ok = ok; it.tag = tag;
    return it;
  endfunction

  function automatic net_item_t tick_item_of(logic [15:0] ms);
    net_item_t it;
    it = noise_item();
    it.op = OpTick; it.elapsed = ms;
    return it;
  endfunction

  // called at a rising edge; returns at a rising edge with valid low
  task automatic send_item(net_item_t it);
    if (!calm && $urandom_range(99) < 8)
      repeat ($urandom_range(6, 1)) @(posedge clk);
    s_axis_tvalid <= 1;
    s_axis_tuser <= it.op;
    s_axis_tdata <= {5'b0, it.elapsed, it.tip, it.smac, it.sip, it.rep, it.ok, it.v4,
                     it.dst, it.tag, it.hop_ip};
    do @(negedge clk); while (!s_axis_tready);
    predict_frames(it);
    @(posedge clk);
    s_axis_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    case (idx)
      RegLocalMac: my_mac = value;
      RegLocalIp:  my_ip = value[31:0];
      RegHoldoff:  holdoff = value[15:0];
      RegLifetime: lifetime = value[19:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [47:0] mac, logic [31:0] ip, logic [15:0] hold,
                            logic [19:0] life);
    drain();
    write_reg(RegLocalMac, mac);
    write_reg(RegLocalIp, {16'b0, ip});
    write_reg(RegHoldoff, {32'b0, hold});
    write_reg(RegLifetime, {28'b0, life});
  endtask

  // reset values: request hold-off, ignored op, frame for someone else
  task automatic test_reset_defaults();
    net_item_t it;
    send_item(send_item_of(32'h0A00_0001, 16'h0001));
    send_item(send_item_of(32'h0A00_0001, 16'h0002));
    it = noise_item();
    it.op = OpUnused;
    send_item(it);
    send_item(ipv4_item_of(48'h0200_0000_0001, 16'h1234, 1));
    send_item(tick_item_of(16'd4999));
    send_item(send_item_of(32'h0A00_0001, 16'h0003));
  endtask

  // learning, flush of queued datagrams, replies, bad payloads, delivery
  task automatic test_resolution();
    send_item(send_item_of(32'h0A00_0001, 16'h0004));
    send_item(arp_item_of(48'h1122_3344_5566, 1, 32'h0A00_0001, 48'hAABB_CCDD_EE01,
                          32'hC0A8_0001, 1));
    send_item(send_item_of(32'h0A00_0001, 16'hFFFF));
    send_item(arp_item_of(BroadcastMac, 0, 32'h0A00_0002, 48'hFFFF_FFFF_FFFE,
                          32'hC0A8_0001, 1));
    send_item(arp_item_of(BroadcastMac, 0, 32'h0A00_0003, 48'h0, 32'hC0A8_0001, 0));
    send_item(ipv4_item_of(48'h1122_3344_5566, 16'hFFFF, 1));
    send_item(ipv4_item_of(BroadcastMac, 16'h0000, 1));
    send_item(ipv4_item_of(48'h1122_3344_5566, 16'h0077, 0));
    // zero lifetime: entry dies on the next nonzero tick
    send_item(tick_item_of(16'hFFFF));
    send_item(send_item_of(32'h0A00_0001, 16'h0005));
  endtask

  // fill the pending queue past its depth
  task automatic test_queue_full();
    for (int i = 0; i < QueueDepth + 1; i++)
      send_item(send_item_of(32'h0B00_0000 + i, 16'(i)));
    send_item(send_item_of(32'h0B00_0003, 16'h00AA));
  endtask

  task automatic test_pause_until_drained();
    send_item(arp_item_of(48'h1122_3344_5566, 1, 32'h0B00_0002, rand48(), $urandom, 1));
    drain();
    send_item(send_item_of(32'h0B00_0002, 16'h0BBB));
  endtask

  task automatic test_random_traffic(int count);
    net_item_t it;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        it = send_item_of(ip_pool[$urandom_range(23)], 16'($urandom));
      end else if (r < 58) begin
        it = arp_item_of(($urandom_range(1)) ? my_mac : BroadcastMac, 1'($urandom),
                         ip_pool[$urandom_range(23)], rand48(),
                         ($urandom_range(1)) ? my_ip : $urandom, $urandom_range(9) > 0);
      end else if (r < 78) begin
        it = tick_item_of(($urandom_range(9) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(3000)));
      end else if (r < 88) begin
        it = ipv4_item_of(($urandom_range(1)) ? my_mac : rand48(), 16'($urandom),
                          1'($urandom));
      end else begin
        it = noise_item();
      end
      send_item(it);
      if (n % 60 == 59)
        set_config(rand48(), $urandom, 16'($urandom_range(8000)),
                   20'($urandom_range(40000)));
    end
  endtask

  initial begin
    my_mac = '0; my_ip = '0; holdoff = HoldoffReset; lifetime = LifetimeReset;
    now_ms = '0;
    foreach (arp_valid[i]) arp_valid[i] = 0;
    foreach (ip_pool[i]) ip_pool[i] = 32'hC0A8_0100 + $urandom_range(255);
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_reset_defaults();
    set_config(48'h1122_3344_5566, 32'hC0A8_0001, 16'd0, 20'd0);
    test_resolution();
    set_config(BroadcastMac, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF);
    test_queue_full();
    test_pause_until_drained();
    set_config(48'h0200_0000_00AA, 32'h0000_0000, HoldoffReset, 20'd20000);
    calm = 1;
    test_random_traffic(50);
    calm = 0;
    test_random_traffic(84);
    drain();
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
